FILE: src/conv3x3_template_filter_top_assert.svh
// ----------------------------------------------------------------------------
// conv3x3_template_filter_top_assert: assertion macros
// Clocked checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_TEMPLATE_FILTER_TOP_ASSERT_SVH
`define CONV3X3_TEMPLATE_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define C3F_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("c3f check failed");
`define C3F_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3f check failed");
`else
`define C3F_CHECK(label, cond)
`define C3F_CHECK_NEXT(label, ante, cons)
`endif

`endif

FILE: src/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants
// Register map, kernel codes and the queued operation record.
// ----------------------------------------------------------------------------
package c3f_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int MODE_W       = 2;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 768;
    localparam int MIN_DIM      = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BOX     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LAPLACE = 2'd2;

    // floor(x / 9) == (x * 3641) >> 15 for x below 32768
    localparam logic [11:0] BOX_RECIP = 12'd3641;
    localparam int          BOX_SHIFT = 15;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    typedef struct packed {
        logic             is_pixel;
        logic [PIX_W-1:0] pixel;
        logic             emit;
        logic             border;
        logic             above_sel;
        logic             row_end;
        logic             frame_end;
    } c3f_op_t;

endpackage

FILE: src/conv3x3_template_filter_top.sv
// ----------------------------------------------------------------------------
// conv3x3_template_filter_top: 3x3 box / Gaussian / Laplacian filter on a pixel stream
// A released result passes the queue, the b, c and d stages and the result register.
// Throughput: one item per cycle unless stalled (one read per line buffer per pixel).
// Reset: clears positions, queue and pipeline; line buffers hold no reset value.
// ----------------------------------------------------------------------------
`include "conv3x3_template_filter_top_assert.svh"

module conv3x3_template_filter_top
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic                  command,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  end_of_row,
    output logic                  end_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int OP_W  = $bits(c3f_op_t);
    localparam int Q_W   = OP_W + COL_W;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    c3f_op_t           q_op_in;
    c3f_op_t           q_op_out;
    logic [COL_W-1:0]  q_addr_in;
    logic [COL_W-1:0]  q_addr_out;
    logic [Q_W-1:0]    q_wdata;
    logic [Q_W-1:0]    q_rdata;
    logic [MODE_W-1:0] kernel_mode;

    c3f_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .command     (command),
        .pixel_in    (pixel_in),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (q_op_in),
        .q_addr      (q_addr_in),
        .kernel_mode (kernel_mode)
    );

    assign q_wdata    = {q_op_in, q_addr_in};
    assign q_op_out   = c3f_op_t'(q_rdata[Q_W-1:COL_W]);
    assign q_addr_out = q_rdata[COL_W-1:0];

    c3f_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    c3f_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .kernel_mode  (kernel_mode),
        .q_valid      (q_valid),
        .q_op         (q_op_out),
        .q_addr       (q_addr_out),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .pixel_out    (pixel_out),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    `C3F_CHECK(a_queue_no_overflow, !(q_push && q_full))
    `C3F_CHECK(a_pop_needs_entry, !(q_pop && !q_valid))
    `C3F_CHECK(a_no_pop_on_held_result, !(res_valid && res_stall && q_pop))
    `C3F_CHECK_NEXT(a_push_lands, q_push, q_valid)

endmodule

FILE: src/c3f_ram.sv
// ----------------------------------------------------------------------------
// c3f_ram: generic single-clock RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module c3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/c3f_fifo.sv
// ----------------------------------------------------------------------------
// c3f_fifo: operation queue between front and back
// Small register FIFO; lets either side stall on its own.
// ----------------------------------------------------------------------------
module c3f_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = data_reg[rd_ptr_reg];

endmodule

FILE: src/c3f_front.sv
// ----------------------------------------------------------------------------
// c3f_front: configuration registers and item classification
// Tracks input and output raster positions and the pending count, decides
// which transfers release a result, and queues work for the back end.
// ----------------------------------------------------------------------------
module c3f_front
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  logic                           command,
    input  logic [PIX_W-1:0]               pixel_in,
    input  logic                           q_full,
    output logic                           q_push,
    output c3f_op_t                        q_op,
    output logic [$clog2(MAX_WIDTH)-1:0]   q_addr,
    output logic [MODE_W-1:0]              kernel_mode
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WCNT_W  = COL_W + 1;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RESET = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WCNT_W-1:0] width_reg,  width_next;
    logic [COL_W-1:0]  wm1_reg,    wm1_next;
    logic [ROW_W-1:0]  hm1_reg,    hm1_next;
    logic [MODE_W-1:0] mode_reg,   mode_next;
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [WCNT_W-1:0] pend_reg,    pend_next;

    logic [31:0] w_clamp;
    logic [31:0] h_clamp;
    logic        cfg_hit;
    logic        accept;
    logic        lag_full;
    logic        flush_ok;
    logic        emit;
    logic        out_col_last;
    logic        out_row_last;

    always_comb
    begin
        w_clamp = 32'(cfg_data[WIDTH_REG_W-1:0]);
        if (w_clamp < 32'(MIN_DIM))
        begin
            w_clamp = 32'(MIN_DIM);
        end
        if (w_clamp > 32'(MAX_WIDTH))
        begin
            w_clamp = 32'(MAX_WIDTH);
        end
        h_clamp = 32'(cfg_data[HEIGHT_REG_W-1:0]);
        if (h_clamp < 32'(MIN_DIM))
        begin
            h_clamp = 32'(MIN_DIM);
        end
        if (h_clamp > 32'(MAX_HEIGHT))
        begin
            h_clamp = 32'(MAX_HEIGHT);
        end
    end

    always_comb
    begin
        width_next = width_reg;
        wm1_next   = wm1_reg;
        hm1_next   = hm1_reg;
        mode_next  = mode_reg;
        cfg_hit    = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = WCNT_W'(w_clamp);
                    wm1_next   = COL_W'(w_clamp - 32'd1);
                    cfg_hit    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    hm1_next = ROW_W'(h_clamp - 32'd1);
                    cfg_hit  = 1'b1;
                end
                REG_KERNEL_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                    cfg_hit   = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign accept       = pix_valid && !q_full;
    assign lag_full     = (pend_reg > width_reg);
    assign flush_ok     = (in_col_reg == '0) && (in_row_reg == '0) && (pend_reg != '0);
    assign emit         = command ? flush_ok : lag_full;
    assign out_col_last = (out_col_reg == wm1_reg);
    assign out_row_last = (out_row_reg == hm1_reg);

    always_comb
    begin
        q_op.is_pixel  = !command;
        q_op.pixel     = pixel_in;
        q_op.emit      = emit;
        q_op.border    = (out_row_reg == '0) || out_row_last || (out_col_reg == '0)
                         || out_col_last;
        q_op.above_sel = lag_full;
        q_op.row_end   = out_col_last;
        q_op.frame_end = out_col_last && out_row_last;
    end

    assign q_addr = command ? out_col_reg : in_col_reg;
    assign q_push = accept && (!command || flush_ok);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (cfg_hit)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end
        else if (accept)
        begin
            if (!command)
            begin
                if (in_col_reg == wm1_reg)
                begin
                    in_col_next = '0;
                    in_row_next = (in_row_reg == hm1_reg) ? '0 : in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (!lag_full)
                begin
                    pend_next = pend_reg + WCNT_W'(1);
                end
            end
            else if (flush_ok)
            begin
                pend_next = pend_reg - WCNT_W'(1);
            end
            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_last ? '0 : out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WCNT_W'(W_RESET);
            wm1_reg     <= COL_W'(W_RESET - 1);
            hm1_reg     <= ROW_W'(H_RESET - 1);
            mode_reg    <= MODE_BOX;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            wm1_reg     <= wm1_next;
            hm1_reg     <= hm1_next;
            mode_reg    <= mode_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

    assign cfg_ready   = 1'b1;
    assign pix_stall   = q_full;
    assign kernel_mode = mode_reg;

endmodule

FILE: src/c3f_back.sv
// ----------------------------------------------------------------------------
// c3f_back: line buffers, 3x3 window and kernel pipeline
// Issue (buffer read) -> window update -> partial sums -> result register.
// The whole pipe advances unless a finished result is held by res_stall.
// ----------------------------------------------------------------------------
module c3f_back
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [MODE_W-1:0]             kernel_mode,
    input  logic                          q_valid,
    input  c3f_op_t                       q_op,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
    output logic                          q_pop,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [PIX_W-1:0]              pixel_out,
    output logic                          end_of_row,
    output logic                          end_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             adv;
    logic             issue;
    logic [PIX_W-1:0] above_rd;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] top;
    logic             above_we;

    logic             b_valid_reg;
    c3f_op_t          b_op_reg;
    logic [COL_W-1:0] b_addr_reg;
    logic             byp_reg;
    logic [PIX_W-1:0] byp_data_reg;

    logic             c_valid_reg;
    c3f_op_t          c_op_reg;
    logic [PIX_W-1:0] c_ram_reg;
    logic [PIX_W-1:0] win_reg [3][3];

    logic             d_valid_reg;
    c3f_op_t          d_op_reg;
    logic [PIX_W-1:0] d_ram_reg;
    logic [PIX_W-1:0] d_centre_reg;
    logic [10:0]      d_ring_reg;
    logic [PIX_W-1:0] d_gauss_reg;

    logic             res_valid_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             eor_reg;
    logic             eof_reg;

    logic [9:0]       corners;
    logic [9:0]       edges;
    logic [10:0]      ring;
    logic [11:0]      gsum;
    logic [11:0]      box_sum;
    logic [23:0]      box_prod;
    logic [11:0]      nine_c;
    logic [12:0]      lap_diff;
    logic [12:0]      lap_mag;
    logic [PIX_W-1:0] lap_val;
    logic [PIX_W-1:0] filt;
    logic [PIX_W-1:0] res_value;

    assign adv      = !res_valid_reg || !res_stall;
    assign issue    = adv && q_valid;
    assign q_pop    = issue;
    assign above_we = adv && b_valid_reg && b_op_reg.is_pixel;

    c3f_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (above_we),
        .waddr (b_addr_reg),
        .wdata (mid_rd),
        .re    (issue),
        .raddr (q_addr),
        .rdata (above_rd)
    );

    c3f_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .clk   (clk),
        .we    (issue && q_op.is_pixel),
        .waddr (q_addr),
        .wdata (q_op.pixel),
        .re    (issue),
        .raddr (q_addr),
        .rdata (mid_rd)
    );

    // line_above is written one stage late; forward it to a read of the same column
    assign top = byp_reg ? byp_data_reg : above_rd;

    always_comb
    begin
        corners = 10'(win_reg[0][0]) + 10'(win_reg[0][2]) + 10'(win_reg[2][0])
                  + 10'(win_reg[2][2]);
        edges   = 10'(win_reg[0][1]) + 10'(win_reg[1][0]) + 10'(win_reg[1][2])
                  + 10'(win_reg[2][1]);
        ring    = 11'(corners) + 11'(edges);
        gsum    = 12'(corners) + {1'b0, edges, 1'b0} + {2'b00, win_reg[1][1], 2'b00};
    end

    always_comb
    begin
        box_sum  = 12'(d_ring_reg) + 12'(d_centre_reg);
        box_prod = 24'(box_sum) * 24'(BOX_RECIP);
        nine_c   = {1'b0, d_centre_reg, 3'b000} + 12'(d_centre_reg);
        lap_diff = 13'(nine_c) - 13'(d_ring_reg);
        lap_mag  = lap_diff[12] ? (13'd0 - lap_diff) : lap_diff;
        lap_val  = (lap_mag > 13'(PIX_MAX)) ? PIX_MAX : lap_mag[PIX_W-1:0];
        unique case (kernel_mode)
            MODE_BOX:     filt = box_prod[BOX_SHIFT +: PIX_W];
            MODE_GAUSS:   filt = d_gauss_reg;
            MODE_LAPLACE: filt = lap_val;
            default:      filt = d_centre_reg;
        endcase
        if (!d_op_reg.is_pixel)
        begin
            res_value = d_ram_reg;
        end
        else if (d_op_reg.border)
        begin
            res_value = d_centre_reg;
        end
        else
        begin
            res_value = filt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int q = 0; q < 3; q++)
                begin
                    win_reg[r][q] <= '0;
                end
            end
        end
        else if (adv)
        begin
            b_valid_reg   <= issue;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            res_valid_reg <= d_valid_reg && d_op_reg.emit;
            if (b_valid_reg && b_op_reg.is_pixel)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= top;
                win_reg[1][2] <= mid_rd;
                win_reg[2][2] <= b_op_reg.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_op_reg      <= q_op;
            b_addr_reg    <= q_addr;
            c_op_reg      <= b_op_reg;
            c_ram_reg     <= b_op_reg.above_sel ? top : mid_rd;
            d_op_reg      <= c_op_reg;
            d_ram_reg     <= c_ram_reg;
            d_centre_reg  <= win_reg[1][1];
            d_ring_reg    <= ring;
            d_gauss_reg   <= gsum[11:4];
            pixel_out_reg <= res_value;
            eor_reg       <= d_op_reg.row_end;
            eof_reg       <= d_op_reg.frame_end;
        end
        if (issue)
        begin
            byp_reg      <= b_valid_reg && b_op_reg.is_pixel && (q_addr == b_addr_reg);
            byp_data_reg <= mid_rd;
        end
    end

    assign res_valid    = res_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign end_of_row   = eor_reg;
    assign end_of_frame = eof_reg;

endmodule
